// ===== design/hsmc_pkg.sv =====
`default_nettype none

package hsmc_pkg;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int DEG_W   = 9;
    localparam int STEP_W  = 6;
    localparam int HOLD_W  = 16;
    localparam int COUNT_W = 23;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;

    // Pass gate and start-up temperature.
    localparam logic [TIME_W-1:0] GATE_MS    = 32'd100;
    localparam logic [DEG_W-1:0]  START_DEG  = 9'd320;
    localparam logic [TIME_W-1:0] MS_PER_SEC = 32'd1000;

    // Division by 1000 as a multiply by a rounded-up reciprocal and a shift.
    // The rounding error is small enough that the quotient is exact for
    // every 32-bit dividend.
    localparam int                RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd274877907;
    localparam int                DIV_SHIFT = 38;
    localparam int                PROD_W    = TIME_W + RECIP_W;

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        REG_STANDBY_TIME = 3'd0,
        REG_OFF_TIME     = 3'd1,
        REG_STANDBY_TEMP = 3'd2,
        REG_MIN_TEMP     = 3'd3,
        REG_MAX_TEMP     = 3'd4,
        REG_TEMP_STEP    = 3'd5,
        REG_LONG_PRESS   = 3'd6,
        REG_MOTION_HOLD  = 3'd7
    } cfg_idx_t;

    // Configuration register values after reset.
    localparam logic [TIME_W-1:0] RST_STANDBY_TIME = 32'd60000;
    localparam logic [TIME_W-1:0] RST_OFF_TIME     = 32'd600000;
    localparam logic [DEG_W-1:0]  RST_STANDBY_TEMP = 9'd150;
    localparam logic [DEG_W-1:0]  RST_MIN_TEMP     = 9'd100;
    localparam logic [DEG_W-1:0]  RST_MAX_TEMP     = 9'd450;
    localparam logic [STEP_W-1:0] RST_TEMP_STEP    = 6'd10;
    localparam logic [HOLD_W-1:0] RST_LONG_PRESS   = 16'd1000;
    localparam logic [HOLD_W-1:0] RST_MOTION_HOLD  = 16'd3000;

    typedef struct packed {
        logic [TIME_W-1:0] standby_time_ms;
        logic [TIME_W-1:0] off_time_ms;
        logic [DEG_W-1:0]  standby_temp;
        logic [DEG_W-1:0]  min_temp;
        logic [DEG_W-1:0]  max_temp;
        logic [STEP_W-1:0] temp_step;
        logic [HOLD_W-1:0] long_press_ms;
        logic [HOLD_W-1:0] motion_hold_ms;
    } cfg_t;

    // One input pass.
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              set_level;
        logic              set_pressed;
        logic              minus_pressed;
        logic              plus_pressed;
        logic              motion_event;
        logic [TIME_W-1:0] motion_time_ms;
    } pass_t;

    // Result of the state update, before the seconds conversion.
    typedef struct packed {
        logic              heat_on;
        logic              standby;
        logic              drive_mode;
        logic [DEG_W-1:0]  target_temp;
        logic [DEG_W-1:0]  selected_temp;
        logic [TIME_W-1:0] remain_ms;
    } rslt_t;

endpackage

`default_nettype wire

// ===== design/hsmc_pass_if.sv =====
`default_nettype none

// Input pass channel.
interface hsmc_pass_if;
    logic                          valid;
    logic                          ready;
    logic [hsmc_pkg::TIME_W-1:0]   now_ms;
    logic                          set_level;
    logic                          set_pressed;
    logic                          minus_pressed;
    logic                          plus_pressed;
    logic                          motion_event;
    logic [hsmc_pkg::TIME_W-1:0]   motion_time_ms;

    modport source (
        output valid, now_ms, set_level, set_pressed, minus_pressed,
               plus_pressed, motion_event, motion_time_ms,
        input  ready
    );

    modport sink (
        input  valid, now_ms, set_level, set_pressed, minus_pressed,
               plus_pressed, motion_event, motion_time_ms,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/hsmc_result_if.sv =====
`default_nettype none

// Result channel.
interface hsmc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          heat_on;
    logic                          standby;
    logic                          drive_mode;
    logic [hsmc_pkg::DEG_W-1:0]    target_temp;
    logic [hsmc_pkg::DEG_W-1:0]    selected_temp;
    logic [hsmc_pkg::COUNT_W-1:0]  countdown_s;

    modport source (
        output valid, heat_on, standby, drive_mode, target_temp,
               selected_temp, countdown_s,
        input  ready
    );

    modport sink (
        input  valid, heat_on, standby, drive_mode, target_temp,
               selected_temp, countdown_s,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/hsmc_core.sv =====
`default_nettype none

// Mode state and its single-pass update. The state advances when step is high.
module hsmc_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hsmc_pkg::cfg_t  cfg,
    input  wire hsmc_pkg::pass_t pass_in,
    input  wire logic           step,
    output logic                has_result,
    output hsmc_pkg::rslt_t      rslt
);

    logic [hsmc_pkg::TIME_W-1:0] last_update_reg, last_update_next;
    logic [hsmc_pkg::TIME_W-1:0] idle_reg, idle_next;
    logic [hsmc_pkg::TIME_W-1:0] press_start_reg, press_start_next;
    logic                        long_press_reg, long_press_next;
    logic                        motion_active_reg, motion_active_next;
    logic [hsmc_pkg::TIME_W-1:0] motion_at_reg, motion_at_next;
    logic                        heat_reg, heat_next;
    logic                        standby_reg, standby_next;
    logic [hsmc_pkg::DEG_W-1:0]  selected_reg, selected_next;
    logic [hsmc_pkg::DEG_W-1:0]  commanded_reg, commanded_next;
    logic                        regulating_reg, regulating_next;

    logic [hsmc_pkg::TIME_W-1:0] elapsed;
    logic                        gated;
    logic [hsmc_pkg::TIME_W:0]   idle_sum;
    logic [hsmc_pkg::DEG_W:0]    floor_sum;
    logic [hsmc_pkg::DEG_W:0]    plus_sum;
    logic [hsmc_pkg::TIME_W-1:0] remain;

    // Next-state logic for one pass.
    always_comb
    begin
        last_update_next   = last_update_reg;
        idle_next          = idle_reg;
        press_start_next   = press_start_reg;
        long_press_next    = long_press_reg;
        motion_active_next = motion_active_reg;
        motion_at_next     = motion_at_reg;
        heat_next          = heat_reg;
        standby_next       = standby_reg;
        selected_next      = selected_reg;
        commanded_next     = commanded_reg;
        regulating_next    = regulating_reg;
        remain             = '0;
        idle_sum           = '0;
        floor_sum          = '0;
        plus_sum           = '0;

        // A motion event is latched on every pass, gated or not.
        if (pass_in.motion_event)
        begin
            motion_active_next = 1'b1;
            motion_at_next     = pass_in.motion_time_ms;
        end

        elapsed = pass_in.now_ms - last_update_reg;
        gated   = (elapsed < hsmc_pkg::GATE_MS);

        if (!gated)
        begin
            // Idle timer, saturating.
            if ((heat_reg && (idle_reg < cfg.standby_time_ms)) ||
                (standby_reg && (idle_reg < cfg.off_time_ms)))
            begin
                idle_sum  = {1'b0, idle_reg} + {1'b0, elapsed};
                idle_next = idle_sum[hsmc_pkg::TIME_W] ? '1
                                                       : idle_sum[hsmc_pkg::TIME_W-1:0];
            end
            last_update_next = pass_in.now_ms;

            // Long-press detection on the raw set level.
            if (pass_in.set_level)
            begin
                if (press_start_reg == '0)
                    press_start_next = pass_in.now_ms;
                if ((pass_in.now_ms - press_start_next) >
                    {{(hsmc_pkg::TIME_W-hsmc_pkg::HOLD_W){1'b0}}, cfg.long_press_ms})
                    long_press_next = 1'b1;
            end
            else if (press_start_reg != '0)
            begin
                press_start_next = '0;
                long_press_next  = 1'b0;
            end

            if (long_press_next)
            begin
                standby_next    = 1'b0;
                heat_next       = 1'b0;
                regulating_next = 1'b0;
            end

            // Minus clamps at the minimum.
            if (pass_in.minus_pressed)
            begin
                floor_sum = {1'b0, cfg.min_temp} +
                            {{(hsmc_pkg::DEG_W+1-hsmc_pkg::STEP_W){1'b0}}, cfg.temp_step};
                if ({1'b0, selected_next} < floor_sum)
                    selected_next = cfg.min_temp;
                else
                    selected_next = selected_next -
                        {{(hsmc_pkg::DEG_W-hsmc_pkg::STEP_W){1'b0}}, cfg.temp_step};
                if (heat_next)
                begin
                    commanded_next  = selected_next;
                    regulating_next = 1'b1;
                end
            end

            // Plus clamps at the maximum and turns heating on.
            if (pass_in.plus_pressed)
            begin
                plus_sum = {1'b0, selected_next} +
                           {{(hsmc_pkg::DEG_W+1-hsmc_pkg::STEP_W){1'b0}}, cfg.temp_step};
                if (plus_sum > {1'b0, cfg.max_temp})
                    selected_next = cfg.max_temp;
                else
                    selected_next = plus_sum[hsmc_pkg::DEG_W-1:0];
                heat_next       = 1'b1;
                commanded_next  = selected_next;
                regulating_next = 1'b1;
            end

            // Any activity restarts heating.
            if (pass_in.set_pressed || pass_in.minus_pressed || pass_in.plus_pressed ||
                motion_active_next)
            begin
                idle_next       = '0;
                heat_next       = 1'b1;
                commanded_next  = selected_next;
                regulating_next = 1'b1;
            end

            // Motion hold expiry.
            if (motion_active_next &&
                ((pass_in.now_ms - motion_at_next) >
                 {{(hsmc_pkg::TIME_W-hsmc_pkg::HOLD_W){1'b0}}, cfg.motion_hold_ms}))
                motion_active_next = 1'b0;

            // Time left to the next drop; under one second means drop now.
            if (heat_next && (cfg.standby_time_ms > idle_next))
            begin
                remain = cfg.standby_time_ms - idle_next;
                if (remain < hsmc_pkg::MS_PER_SEC)
                begin
                    standby_next    = 1'b1;
                    heat_next       = 1'b0;
                    commanded_next  = cfg.standby_temp;
                    regulating_next = 1'b1;
                    idle_next       = '0;
                end
            end
            else if (standby_next && (cfg.off_time_ms > idle_next))
            begin
                remain = cfg.off_time_ms - idle_next;
                if (remain < hsmc_pkg::MS_PER_SEC)
                begin
                    standby_next    = 1'b0;
                    heat_next       = 1'b0;
                    regulating_next = 1'b0;
                    idle_next       = '0;
                end
            end
        end
    end

    // Result of this pass.
    always_comb
    begin
        has_result         = !gated;
        rslt.heat_on       = heat_next;
        rslt.standby       = standby_next;
        rslt.drive_mode    = regulating_next;
        rslt.target_temp   = commanded_next;
        rslt.selected_temp = selected_next;
        rslt.remain_ms     = remain;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_update_reg   <= '0;
            idle_reg          <= '0;
            press_start_reg   <= '0;
            long_press_reg    <= 1'b0;
            motion_active_reg <= 1'b0;
            motion_at_reg     <= '0;
            heat_reg          <= 1'b0;
            standby_reg       <= 1'b1;
            selected_reg      <= hsmc_pkg::START_DEG;
            commanded_reg     <= hsmc_pkg::RST_STANDBY_TEMP;
            regulating_reg    <= 1'b1;
        end
        else if (step)
        begin
            last_update_reg   <= last_update_next;
            idle_reg          <= idle_next;
            press_start_reg   <= press_start_next;
            long_press_reg    <= long_press_next;
            motion_active_reg <= motion_active_next;
            motion_at_reg     <= motion_at_next;
            heat_reg          <= heat_next;
            standby_reg       <= standby_next;
            selected_reg      <= selected_next;
            commanded_reg     <= commanded_next;
            regulating_reg    <= regulating_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/heater_standby_mode_controller_top.sv =====
// A pass goes through the input register, the state-update result register and the
// output register. Throughput: one pass per cycle while the result channel is ready;
// the seconds conversion is a pipelined reciprocal multiply.
// Passes inside the 100 ms gate give no result. Reset is asynchronous, active low:
// it empties the pipeline and loads the reset values of state and registers.
`default_nettype none

module heater_standby_mode_controller_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [hsmc_pkg::ADDR_W-1:0]  cfg_addr,
    input  wire logic [hsmc_pkg::CFG_W-1:0]   cfg_wdata,
    hsmc_pass_if.sink                         pass,
    hsmc_result_if.source                     result
);

    hsmc_pkg::cfg_t  cfg_reg;

    logic            s0_valid_reg;
    hsmc_pkg::pass_t s0_pass_reg;
    logic            s1_valid_reg;
    hsmc_pkg::rslt_t s1_rslt_reg;
    logic            s2_valid_reg;
    hsmc_pkg::rslt_t s2_rslt_reg;
    logic [hsmc_pkg::PROD_W-1:0] s2_prod_reg, s2_prod_next;

    logic            s0_free, s1_free, s2_free;
    logic            step;
    logic            has_result;
    hsmc_pkg::rslt_t core_rslt;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.standby_time_ms <= hsmc_pkg::RST_STANDBY_TIME;
            cfg_reg.off_time_ms     <= hsmc_pkg::RST_OFF_TIME;
            cfg_reg.standby_temp    <= hsmc_pkg::RST_STANDBY_TEMP;
            cfg_reg.min_temp        <= hsmc_pkg::RST_MIN_TEMP;
            cfg_reg.max_temp        <= hsmc_pkg::RST_MAX_TEMP;
            cfg_reg.temp_step       <= hsmc_pkg::RST_TEMP_STEP;
            cfg_reg.long_press_ms   <= hsmc_pkg::RST_LONG_PRESS;
            cfg_reg.motion_hold_ms  <= hsmc_pkg::RST_MOTION_HOLD;
        end
        else if (cfg_we)
        begin
            unique case (hsmc_pkg::cfg_idx_t'(cfg_addr))
                hsmc_pkg::REG_STANDBY_TIME: cfg_reg.standby_time_ms <= cfg_wdata;
                hsmc_pkg::REG_OFF_TIME:     cfg_reg.off_time_ms     <= cfg_wdata;
                hsmc_pkg::REG_STANDBY_TEMP:
                    cfg_reg.standby_temp <= cfg_wdata[hsmc_pkg::DEG_W-1:0];
                hsmc_pkg::REG_MIN_TEMP:
                    cfg_reg.min_temp <= cfg_wdata[hsmc_pkg::DEG_W-1:0];
                hsmc_pkg::REG_MAX_TEMP:
                    cfg_reg.max_temp <= cfg_wdata[hsmc_pkg::DEG_W-1:0];
                hsmc_pkg::REG_TEMP_STEP:
                    cfg_reg.temp_step <= cfg_wdata[hsmc_pkg::STEP_W-1:0];
                hsmc_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_ms <= cfg_wdata[hsmc_pkg::HOLD_W-1:0];
                hsmc_pkg::REG_MOTION_HOLD:
                    cfg_reg.motion_hold_ms <= cfg_wdata[hsmc_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage takes new data when it is empty or drains.
    assign s2_free    = !s2_valid_reg || result.ready;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign s0_free    = !s0_valid_reg || s1_free;
    assign step       = s0_valid_reg && s1_free;
    assign pass.ready = s0_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_free)
            s0_valid_reg <= pass.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_free && pass.valid)
        begin
            s0_pass_reg.now_ms         <= pass.now_ms;
            s0_pass_reg.set_level      <= pass.set_level;
            s0_pass_reg.set_pressed    <= pass.set_pressed;
            s0_pass_reg.minus_pressed  <= pass.minus_pressed;
            s0_pass_reg.plus_pressed   <= pass.plus_pressed;
            s0_pass_reg.motion_event   <= pass.motion_event;
            s0_pass_reg.motion_time_ms <= pass.motion_time_ms;
        end
    end

    // Mode state update.
    hsmc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pass_in    (s0_pass_reg),
        .step       (step),
        .has_result (has_result),
        .rslt       (core_rslt)
    );

    // Result register of the state update; gated passes leave a bubble.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= step && has_result;
    end

    always_ff @(posedge clk)
    begin
        if (step && has_result)
            s1_rslt_reg <= core_rslt;
    end

    // Milliseconds to whole seconds by reciprocal multiply.
    assign s2_prod_next = hsmc_pkg::PROD_W'(s1_rslt_reg.remain_ms) *
                          hsmc_pkg::PROD_W'(hsmc_pkg::DIV_RECIP);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_rslt_reg <= s1_rslt_reg;
            s2_prod_reg <= s2_prod_next;
        end
    end

    // Result channel.
    assign result.valid         = s2_valid_reg;
    assign result.heat_on       = s2_rslt_reg.heat_on;
    assign result.standby       = s2_rslt_reg.standby;
    assign result.drive_mode    = s2_rslt_reg.drive_mode;
    assign result.target_temp   = s2_rslt_reg.target_temp;
    assign result.selected_temp = s2_rslt_reg.selected_temp;
    assign result.countdown_s   =
        s2_prod_reg[hsmc_pkg::DIV_SHIFT+hsmc_pkg::COUNT_W-1:hsmc_pkg::DIV_SHIFT];

endmodule

`default_nettype wire

// ===== bench/tb_heater_standby_mode_controller_top.sv =====
`timescale 1ns / 1ps

// One result as it appears on the result channel.
typedef struct packed {
    logic                              heat_on;
    logic                              standby;
    logic                              drive_mode;
    logic [hsmc_pkg::DEG_W-1:0]        target_temp;
    logic [hsmc_pkg::DEG_W-1:0]        selected_temp;
    logic [hsmc_pkg::COUNT_W-1:0]      countdown_s;
} hsmc_status_t;

// Tracks the controller state, predicts the status of every accepted pass and
// checks the results coming out of the block against those predictions.
class heater_status_board;
    hsmc_pkg::cfg_t                    cfg;
    logic [hsmc_pkg::TIME_W-1:0]       last_upd_ms;
    logic [hsmc_pkg::TIME_W-1:0]       idle_ms;
    logic [hsmc_pkg::TIME_W-1:0]       press_ms;
    logic [hsmc_pkg::TIME_W-1:0]       motion_ms;
    bit                                long_hold;
    bit                                motion_on;
    bit                                heating;
    bit                                standing_by;
    bit                                regulating;
    logic [hsmc_pkg::DEG_W-1:0]        chosen_deg;
    logic [hsmc_pkg::DEG_W-1:0]        target_deg;
    hsmc_status_t                      pending_status[$];
    int                                errors;

    function new();
        cfg.standby_time_ms = hsmc_pkg::RST_STANDBY_TIME;
        cfg.off_time_ms     = hsmc_pkg::RST_OFF_TIME;
        cfg.standby_temp    = hsmc_pkg::RST_STANDBY_TEMP;
        cfg.min_temp        = hsmc_pkg::RST_MIN_TEMP;
        cfg.max_temp        = hsmc_pkg::RST_MAX_TEMP;
        cfg.temp_step       = hsmc_pkg::RST_TEMP_STEP;
        cfg.long_press_ms   = hsmc_pkg::RST_LONG_PRESS;
        cfg.motion_hold_ms  = hsmc_pkg::RST_MOTION_HOLD;
        last_upd_ms = '0;
        idle_ms     = '0;
        press_ms    = '0;
        motion_ms   = '0;
        long_hold   = 1'b0;
        motion_on   = 1'b0;
        heating     = 1'b0;
        standing_by = 1'b1;
        regulating  = 1'b1;
        chosen_deg  = hsmc_pkg::START_DEG;
        target_deg  = hsmc_pkg::RST_STANDBY_TEMP;
        errors      = 0;
    endfunction

    // A register write keeps only the bits of the register's own width.
    function void write_reg(hsmc_pkg::cfg_idx_t idx, logic [hsmc_pkg::CFG_W-1:0] data);
        case (idx)
            hsmc_pkg::REG_STANDBY_TIME: cfg.standby_time_ms = data;
            hsmc_pkg::REG_OFF_TIME:     cfg.off_time_ms     = data;
            hsmc_pkg::REG_STANDBY_TEMP: cfg.standby_temp    = data[hsmc_pkg::DEG_W-1:0];
            hsmc_pkg::REG_MIN_TEMP:     cfg.min_temp        = data[hsmc_pkg::DEG_W-1:0];
            hsmc_pkg::REG_MAX_TEMP:     cfg.max_temp        = data[hsmc_pkg::DEG_W-1:0];
            hsmc_pkg::REG_TEMP_STEP:    cfg.temp_step       = data[hsmc_pkg::STEP_W-1:0];
            hsmc_pkg::REG_LONG_PRESS:   cfg.long_press_ms   = data[hsmc_pkg::HOLD_W-1:0];
            hsmc_pkg::REG_MOTION_HOLD:  cfg.motion_hold_ms  = data[hsmc_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    function void regulate_to(logic [hsmc_pkg::DEG_W-1:0] deg);
        target_deg = deg;
        regulating = 1'b1;
    endfunction

    // Update the state for one accepted pass and queue its status, if any.
    function void apply_pass(hsmc_pkg::pass_t p);
        logic [31:0]  elapsed;
        logic [31:0]  limit;
        logic [31:0]  deg;
        logic [31:0]  secs;
        hsmc_status_t st;
        secs = '0;

        // Motion is latched even when the pass is gated.
        if (p.motion_event) begin
            motion_on = 1'b1;
            motion_ms = p.motion_time_ms;
        end

        elapsed = p.now_ms - last_upd_ms;
        if (elapsed < hsmc_pkg::GATE_MS)
            return;

        // Idle timer runs only while a drop is still ahead; it saturates.
        if ((heating && idle_ms < cfg.standby_time_ms) ||
            (standing_by && idle_ms < cfg.off_time_ms)) begin
            idle_ms = (idle_ms > 32'hFFFF_FFFF - elapsed) ? 32'hFFFF_FFFF : idle_ms + elapsed;
        end
        last_upd_ms = p.now_ms;

        // Set-button hold tracking; a start time of zero means not held.
        if (p.set_level) begin
            if (press_ms == '0)
                press_ms = p.now_ms;
            if ((p.now_ms - press_ms) > {16'd0, cfg.long_press_ms})
                long_hold = 1'b1;
        end else if (press_ms != '0) begin
            press_ms  = '0;
            long_hold = 1'b0;
        end

        if (long_hold) begin
            standing_by = 1'b0;
            heating     = 1'b0;
            regulating  = 1'b0;
        end

        // Minus clamps at the minimum without wrapping.
        if (p.minus_pressed) begin
            limit = {23'd0, cfg.min_temp} + {26'd0, cfg.temp_step};
            if ({23'd0, chosen_deg} < limit)
                chosen_deg = cfg.min_temp;
            else
                chosen_deg = chosen_deg - {3'd0, cfg.temp_step};
            if (heating)
                regulate_to(chosen_deg);
        end

        // Plus clamps at the maximum.
        if (p.plus_pressed) begin
            deg = {23'd0, chosen_deg} + {26'd0, cfg.temp_step};
            if (deg > {23'd0, cfg.max_temp})
                deg = {23'd0, cfg.max_temp};
            chosen_deg = deg[hsmc_pkg::DEG_W-1:0];
            heating = 1'b1;
            regulate_to(chosen_deg);
        end

        // Any activity restarts heating.
        if (p.set_pressed || p.minus_pressed || p.plus_pressed || motion_on) begin
            idle_ms = '0;
            heating = 1'b1;
            regulate_to(chosen_deg);
        end

        if (motion_on && (p.now_ms - motion_ms) > {16'd0, cfg.motion_hold_ms})
            motion_on = 1'b0;

        // Countdown to the next mode drop; a zero count performs the drop.
        if (heating && cfg.standby_time_ms > idle_ms) begin
            secs = (cfg.standby_time_ms - idle_ms) / hsmc_pkg::MS_PER_SEC;
            if (secs == '0) begin
                standing_by = 1'b1;
                heating     = 1'b0;
                regulate_to(cfg.standby_temp);
                idle_ms     = '0;
            end
        end else if (standing_by && cfg.off_time_ms > idle_ms) begin
            secs = (cfg.off_time_ms - idle_ms) / hsmc_pkg::MS_PER_SEC;
            if (secs == '0) begin
                standing_by = 1'b0;
                heating     = 1'b0;
                regulating  = 1'b0;
                idle_ms     = '0;
            end
        end

        st.heat_on       = heating;
        st.standby       = standing_by;
        st.drive_mode    = regulating;
        st.target_temp   = target_deg;
        st.selected_temp = chosen_deg;
        st.countdown_s   = secs[hsmc_pkg::COUNT_W-1:0];
        pending_status.push_back(st);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Check one result transaction against the oldest prediction.
    function void check_status(hsmc_status_t got);
        hsmc_status_t want;
        if (pending_status.size() == 0) begin
            $error("result transaction arrived with no prediction pending");
            errors++;
            return;
        end
        want = pending_status.pop_front();
        compare_field("heat_on", 32'(want.heat_on), 32'(got.heat_on));
        compare_field("standby", 32'(want.standby), 32'(got.standby));
        compare_field("drive_mode", 32'(want.drive_mode), 32'(got.drive_mode));
        compare_field("target_temp", 32'(want.target_temp), 32'(got.target_temp));
        compare_field("selected_temp", 32'(want.selected_temp), 32'(got.selected_temp));
        compare_field("countdown_s", 32'(want.countdown_s), 32'(got.countdown_s));
    endfunction
endclass

module tb_heater_standby_mode_controller_top;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [hsmc_pkg::ADDR_W-1:0]     cfg_addr;
    logic [hsmc_pkg::CFG_W-1:0]      cfg_wdata;

    hsmc_pass_if   pass_ch();
    hsmc_result_if result_ch();

    heater_status_board board = new();

    // Stimulus bookkeeping.
    logic [hsmc_pkg::TIME_W-1:0]     clock_ms;
    bit                              holding;
    int                              burst_left;
    int                              hold_requests;

    heater_standby_mode_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pass      (pass_ch),
        .result    (result_ch)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: stalls on a changing random pattern, and holds off for a long
    // stretch whenever the stimulus asks for it.
    initial begin : receiver
        int hold_left;
        int stall_pct;
        int pattern_left;
        int served;
        hold_left    = 0;
        stall_pct    = 0;
        pattern_left = 0;
        served       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = 400;
            end
            if (pattern_left == 0) begin
                pattern_left = int'($urandom_range(16, 96));
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready = 1'b0;
            end else begin
                result_ch.ready = (int'($urandom_range(0, 99)) >= stall_pct);
            end
        end
    end

    // Every accepted result transaction is checked.
    always @(posedge clk) begin
        hsmc_status_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got.heat_on       = result_ch.heat_on;
            got.standby       = result_ch.standby;
            got.drive_mode    = result_ch.drive_mode;
            got.target_temp   = result_ch.target_temp;
            got.selected_temp = result_ch.selected_temp;
            got.countdown_s   = result_ch.countdown_s;
            board.check_status(got);
        end
    end

    // Offer one pass in bursts with random gaps; hands it to the predictor once
    // the transaction completes.
    task automatic send_pass(input hsmc_pkg::pass_t p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            repeat (gap) @(negedge clk) pass_ch.valid = 1'b0;
            burst_left = int'($urandom_range(1, 16));
        end
        burst_left--;
        @(negedge clk);
        pass_ch.valid          = 1'b1;
        pass_ch.now_ms         = p.now_ms;
        pass_ch.set_level      = p.set_level;
        pass_ch.set_pressed    = p.set_pressed;
        pass_ch.minus_pressed  = p.minus_pressed;
        pass_ch.plus_pressed   = p.plus_pressed;
        pass_ch.motion_event   = p.motion_event;
        pass_ch.motion_time_ms = p.motion_time_ms;
        @(posedge clk);
        while (!pass_ch.ready) @(posedge clk);
        board.apply_pass(p);
    endtask

    task automatic pass_at(input logic [hsmc_pkg::TIME_W-1:0] at_ms, input bit lvl,
                           input bit set_p, input bit minus_p, input bit plus_p,
                           input bit mot, input logic [hsmc_pkg::TIME_W-1:0] mot_ms);
        hsmc_pkg::pass_t p;
        p.now_ms         = at_ms;
        p.set_level      = lvl;
        p.set_pressed    = set_p;
        p.minus_pressed  = minus_p;
        p.plus_pressed   = plus_p;
        p.motion_event   = mot;
        p.motion_time_ms = mot_ms;
        clock_ms = at_ms;
        send_pass(p);
    endtask

    // Random pass: time mostly moves forward past the gate, with some gated
    // passes and large jumps; set is held in runs so long presses happen.
    function automatic hsmc_pkg::pass_t next_pass(input int act_pct);
        hsmc_pkg::pass_t p;
        int    r;
        r = int'($urandom_range(0, 99));
        if (r < 10)
            clock_ms = clock_ms + $urandom_range(0, 99);
        else if (r < 75)
            clock_ms = clock_ms + $urandom_range(100, 2500);
        else if (r < 90)
            clock_ms = clock_ms + $urandom_range(2500, 20000);
        else if (r < 95)
            clock_ms = clock_ms + $urandom();
        else
            clock_ms = clock_ms + hsmc_pkg::GATE_MS;
        if (holding)
            holding = ($urandom_range(0, 99) >= 15);
        else
            holding = ($urandom_range(0, 99) < 10);
        p.now_ms        = clock_ms;
        p.set_level     = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 1) == 1 : holding;
        p.set_pressed   = (int'($urandom_range(0, 99)) < act_pct);
        p.minus_pressed = (int'($urandom_range(0, 99)) < act_pct);
        p.plus_pressed  = (int'($urandom_range(0, 99)) < act_pct);
        p.motion_event  = (int'($urandom_range(0, 99)) < act_pct);
        if ($urandom_range(0, 4) == 0)
            p.motion_time_ms = $urandom();
        else
            p.motion_time_ms = clock_ms - $urandom_range(0, 6000);
        return p;
    endfunction

    task automatic random_passes(input int count, input int act_pct);
        repeat (count) send_pass(next_pass(act_pct));
    endtask

    // Wait until every predicted result has come out, then let the pipeline
    // settle so no gated pass is still in flight.
    task automatic drain();
        @(negedge clk) pass_ch.valid = 1'b0;
        while (board.pending_status.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Narrow registers get random bits above their width.
    function automatic logic [hsmc_pkg::CFG_W-1:0] with_noise(
        input logic [hsmc_pkg::CFG_W-1:0] v, input int w);
        logic [hsmc_pkg::CFG_W-1:0] mask;
        mask = (32'h1 << w) - 32'h1;
        return (v & mask) | ($urandom() & ~mask);
    endfunction

    task automatic write_reg(input hsmc_pkg::cfg_idx_t idx,
                             input logic [hsmc_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic apply_config(input hsmc_pkg::cfg_t c);
        write_reg(hsmc_pkg::REG_STANDBY_TIME, c.standby_time_ms);
        write_reg(hsmc_pkg::REG_OFF_TIME, c.off_time_ms);
        write_reg(hsmc_pkg::REG_STANDBY_TEMP,
                  with_noise(32'(c.standby_temp), hsmc_pkg::DEG_W));
        write_reg(hsmc_pkg::REG_MIN_TEMP, with_noise(32'(c.min_temp), hsmc_pkg::DEG_W));
        write_reg(hsmc_pkg::REG_MAX_TEMP, with_noise(32'(c.max_temp), hsmc_pkg::DEG_W));
        write_reg(hsmc_pkg::REG_TEMP_STEP, with_noise(32'(c.temp_step), hsmc_pkg::STEP_W));
        write_reg(hsmc_pkg::REG_LONG_PRESS,
                  with_noise(32'(c.long_press_ms), hsmc_pkg::HOLD_W));
        write_reg(hsmc_pkg::REG_MOTION_HOLD,
                  with_noise(32'(c.motion_hold_ms), hsmc_pkg::HOLD_W));
        @(negedge clk) cfg_we = 1'b0;
    endtask

    function automatic hsmc_pkg::cfg_t random_cfg();
        hsmc_pkg::cfg_t c;
        c.standby_time_ms = $urandom_range(1000, 20000);
        c.off_time_ms     = $urandom_range(2000, 40000);
        c.standby_temp    = hsmc_pkg::DEG_W'($urandom_range(0, 511));
        c.min_temp        = hsmc_pkg::DEG_W'($urandom_range(0, 300));
        c.max_temp        = hsmc_pkg::DEG_W'($urandom_range(200, 511));
        c.temp_step       = hsmc_pkg::STEP_W'($urandom_range(1, 63));
        c.long_press_ms   = hsmc_pkg::HOLD_W'($urandom_range(0, 3000));
        c.motion_hold_ms  = hsmc_pkg::HOLD_W'($urandom_range(0, 5000));
        return c;
    endfunction

    // Main stimulus.
    initial begin
        hsmc_pkg::cfg_t c;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_addr               = '0;
        cfg_wdata              = '0;
        pass_ch.valid          = 1'b0;
        pass_ch.now_ms         = '0;
        pass_ch.set_level      = 1'b0;
        pass_ch.set_pressed    = 1'b0;
        pass_ch.minus_pressed  = 1'b0;
        pass_ch.plus_pressed   = 1'b0;
        pass_ch.motion_event   = 1'b0;
        pass_ch.motion_time_ms = '0;
        clock_ms      = '0;
        holding       = 1'b0;
        burst_left    = 0;
        hold_requests = 0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Reset settings: gate edges, presses, long press, wrap of time and a
        // press that starts at time zero.
        pass_at(32'd50, 0, 0, 0, 0, 1, 32'd40);
        pass_at(32'd99, 0, 0, 0, 0, 0, 32'd0);
        pass_at(32'd100, 0, 0, 0, 0, 0, 32'd0);
        pass_at(32'd200, 0, 0, 0, 1, 0, 32'd0);
        pass_at(32'd300, 0, 0, 1, 0, 0, 32'd0);
        pass_at(32'd400, 0, 1, 1, 1, 0, 32'd0);
        pass_at(32'd5000, 1, 0, 0, 0, 0, 32'd0);
        pass_at(32'd6001, 1, 0, 0, 0, 0, 32'd0);
        pass_at(32'd6101, 1, 1, 0, 0, 0, 32'd0);
        pass_at(32'd6201, 0, 0, 0, 0, 0, 32'd0);
        pass_at(32'd6301, 0, 0, 0, 0, 1, 32'hFFFF_FFFF);
        pass_at(32'hFFFF_FF80, 0, 0, 0, 0, 0, 32'd0);
        pass_at(32'd0, 1, 0, 0, 0, 0, 32'd0);
        pass_at(32'h100, 1, 0, 0, 0, 0, 32'd0);
        pass_at(32'h200, 0, 0, 0, 0, 0, 32'd0);
        random_passes(100, 8);
        drain();

        // Short timers, lowest temperatures, largest step: drops to standby
        // and then off, and minus clamping at zero.
        c.standby_time_ms = 32'd3000;
        c.off_time_ms     = 32'd6000;
        c.standby_temp    = '0;
        c.min_temp        = '0;
        c.max_temp        = 9'd511;
        c.temp_step       = 6'd63;
        c.long_press_ms   = '0;
        c.motion_hold_ms  = '0;
        apply_config(c);
        pass_at(clock_ms + 32'd200, 0, 0, 0, 1, 0, 32'd0);
        pass_at(clock_ms + 32'd2100, 0, 0, 0, 0, 0, 32'd0);
        pass_at(clock_ms + 32'd5500, 0, 0, 0, 0, 0, 32'd0);
        pass_at(clock_ms + 32'd200, 0, 0, 1, 0, 0, 32'd0);
        pass_at(clock_ms + 32'd200, 0, 0, 1, 0, 0, 32'd0);
        random_passes(100, 5);
        drain();

        // Largest values, minimum above maximum, idle timer saturation.
        c.standby_time_ms = 32'hFFFF_FFFF;
        c.off_time_ms     = 32'hFFFF_FFFF;
        c.standby_temp    = 9'd511;
        c.min_temp        = 9'd511;
        c.max_temp        = '0;
        c.temp_step       = 6'd1;
        c.long_press_ms   = 16'hFFFF;
        c.motion_hold_ms  = 16'hFFFF;
        apply_config(c);
        pass_at(clock_ms + 32'd70000, 0, 0, 0, 0, 0, 32'd0);
        pass_at(clock_ms + 32'd200, 0, 0, 1, 0, 0, 32'd0);
        pass_at(clock_ms + 32'd200, 0, 0, 0, 1, 0, 32'd0);
        pass_at(clock_ms + 32'd200, 0, 0, 0, 0, 0, 32'd0);
        pass_at(clock_ms + 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 32'd0);
        random_passes(100, 5);
        drain();

        // Zero timers.
        c.standby_time_ms = '0;
        c.off_time_ms     = '0;
        c.standby_temp    = 9'd511;
        c.min_temp        = '0;
        c.max_temp        = 9'd511;
        c.temp_step       = 6'd1;
        c.long_press_ms   = '0;
        c.motion_hold_ms  = '0;
        apply_config(c);
        random_passes(80, 10);
        drain();

        // Random settings; the receiver holds off long enough to fill the block.
        apply_config(random_cfg());
        random_passes(40, 6);
        hold_requests = hold_requests + 1;
        random_passes(70, 6);
        drain();

        apply_config(random_cfg());
        random_passes(110, 12);
        drain();

        if (board.errors == 0 && board.pending_status.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
